// ----- src/dqqp_pkg.sv -----
// Package for the DNS query question parser: payload structs, phase and
// result-kind codes. No dependencies.
`default_nettype none

package dqqp_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LENGTH = 3'd1,
    PH_CHARS  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_SKIP   = 3'd4
  } phase_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_QUERY_OK  = 3'd1,
    KIND_SHORT_HDR = 3'd2,
    KIND_RESPONSE  = 3'd3,
    KIND_TRUNCATED = 3'd4,
    KIND_NAME_LONG = 3'd5
  } kind_e;

  localparam int unsigned HeaderBytes = 12;
  localparam logic [7:0]  DotChar     = 8'h2E;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  name_char;
    logic [15:0] query_id;
    logic [15:0] flag_bits;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [7:0]  name_length;
    logic        final_result;
  } out_t;

endpackage

`default_nettype wire

// ----- src/dns_query_question_parser_core.sv -----
// DNS query header and first-question parser, top level.
// Depends on dqqp_pkg.
//
//  channel | direction | handshake                       | payload
//  --------+-----------+---------------------------------+----------------
//  in      | input     | in_valid_i / in_ready_o         | dqqp_pkg::in_t
//  out     | output    | out_valid_o / out_ready_i       | dqqp_pkg::out_t
//
// One message byte is taken per cycle while in_ready_o is high; the parse state updates in the cycle
// of acceptance and any result is registered into the output stage.
// A two-entry output stage (output register plus skid register) holds results;
// in_ready_o drops only while the skid register is occupied.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase
// with all words cleared and drops both output entries.
`default_nettype none

module dns_query_question_parser_core #(
  parameter int unsigned MAX_NAME_LEN = 255
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dqqp_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output dqqp_pkg::out_t      out_data_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_NAME_LEN);

  // Parse state
  dqqp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  bpos_q, bpos_d;
  logic [15:0] id_q, id_d, flags_q, flags_d, qd_q, qd_d;
  logic [15:0] an_q, an_d, ns_q, ns_d, ar_q, ar_d;
  logic [15:0] type_q, type_d, class_q, class_d;
  logic [7:0]  left_q, left_d, count_q, count_d;
  logic        first_q, first_d;

  // Step outcome
  logic             accept;
  logic             emit;
  dqqp_pkg::kind_e  emit_kind;
  logic [7:0]       emit_char;
  logic             restart;   // last byte of the message: clear all
  dqqp_pkg::out_t   result;

  // Output stage
  logic             out_valid_q, skid_valid_q;
  dqqp_pkg::out_t   out_q, skid_q;
  logic             pop, push;

  logic [7:0] b;
  logic       last;
  logic [3:0] bpos_inc;

  assign accept   = in_valid_i && in_ready_o;
  assign b        = in_data_i.data_byte;
  assign last     = in_data_i.is_last;
  assign bpos_inc = bpos_q + 4'd1;

  // Next-state logic: updated words first, then restart clears them
  always_comb begin
    phase_d   = phase_q;
    bpos_d    = bpos_q;
    id_d      = id_q;
    flags_d   = flags_q;
    qd_d      = qd_q;
    an_d      = an_q;
    ns_d      = ns_q;
    ar_d      = ar_q;
    type_d    = type_q;
    class_d   = class_q;
    left_d    = left_q;
    count_d   = count_q;
    first_d   = first_q;
    emit      = 1'b0;
    emit_kind = dqqp_pkg::KIND_CHAR;
    emit_char = 8'd0;
    restart   = 1'b0;

    unique case (phase_q)
      dqqp_pkg::PH_HEADER: begin
        // shift the byte into the word picked by the byte pair index
        case (bpos_q[3:1])
          3'd0:    id_d    = {id_q[7:0], b};
          3'd1:    flags_d = {flags_q[7:0], b};
          3'd2:    qd_d    = {qd_q[7:0], b};
          3'd3:    an_d    = {an_q[7:0], b};
          3'd4:    ns_d    = {ns_q[7:0], b};
          default: ar_d    = {ar_q[7:0], b};
        endcase
        bpos_d = bpos_inc;
        if (bpos_inc < 4'(dqqp_pkg::HeaderBytes)) begin
          if (last) begin
            emit = 1'b1; emit_kind = dqqp_pkg::KIND_SHORT_HDR; restart = 1'b1;
          end
        end else if (flags_d[15]) begin
          emit = 1'b1; emit_kind = dqqp_pkg::KIND_RESPONSE;
          restart = last;
          phase_d = dqqp_pkg::PH_SKIP;
        end else if (last) begin
          emit = 1'b1; emit_kind = dqqp_pkg::KIND_TRUNCATED; restart = 1'b1;
        end else begin
          phase_d = dqqp_pkg::PH_LENGTH;
          bpos_d  = 4'd0;
        end
      end

      dqqp_pkg::PH_LENGTH: begin
        if (b == 8'd0) begin
          if (last) begin
            emit = 1'b1; emit_kind = dqqp_pkg::KIND_TRUNCATED; restart = 1'b1;
          end else begin
            phase_d = dqqp_pkg::PH_TAIL;
            bpos_d  = 4'd0;
          end
        end else if (!first_q) begin
          // later label: a dot goes out first
          if (count_q >= MaxLen) begin
            emit = 1'b1; emit_kind = dqqp_pkg::KIND_NAME_LONG;
            restart = last;
            phase_d = dqqp_pkg::PH_SKIP;
          end else if (last) begin
            emit = 1'b1; emit_kind = dqqp_pkg::KIND_TRUNCATED; restart = 1'b1;
          end else begin
            count_d   = count_q + 8'd1;
            left_d    = b;
            phase_d   = dqqp_pkg::PH_CHARS;
            emit      = 1'b1;
            emit_char = dqqp_pkg::DotChar;
          end
        end else if (last) begin
          emit = 1'b1; emit_kind = dqqp_pkg::KIND_TRUNCATED; restart = 1'b1;
        end else begin
          first_d = 1'b0;
          left_d  = b;
          phase_d = dqqp_pkg::PH_CHARS;
        end
      end

      dqqp_pkg::PH_CHARS: begin
        if (count_q >= MaxLen) begin
          emit = 1'b1; emit_kind = dqqp_pkg::KIND_NAME_LONG;
          restart = last;
          phase_d = dqqp_pkg::PH_SKIP;
        end else if (last) begin
          emit = 1'b1; emit_kind = dqqp_pkg::KIND_TRUNCATED; restart = 1'b1;
        end else begin
          count_d   = count_q + 8'd1;
          left_d    = left_q - 8'd1;
          if (left_d == 8'd0) phase_d = dqqp_pkg::PH_LENGTH;
          emit      = 1'b1;
          emit_char = b;
        end
      end

      dqqp_pkg::PH_TAIL: begin
        if (bpos_q < 4'd2) type_d  = {type_q[7:0], b};
        else               class_d = {class_q[7:0], b};
        bpos_d = bpos_inc;
        if (bpos_inc >= 4'd4) begin
          emit = 1'b1; emit_kind = dqqp_pkg::KIND_QUERY_OK;
          restart = last;
          phase_d = dqqp_pkg::PH_SKIP;
        end else if (last) begin
          emit = 1'b1; emit_kind = dqqp_pkg::KIND_TRUNCATED; restart = 1'b1;
        end
      end

      default: begin
        // skip phase and unused codes: wait for the end of the message
        restart = last;
      end
    endcase
  end

  // Result formation from the updated words
  always_comb begin
    result.kind             = emit_kind;
    result.name_char        = emit_char;
    result.query_id         = id_d;
    result.flag_bits        = flags_d;
    result.question_count   = qd_d;
    result.answer_count     = an_d;
    result.authority_count  = ns_d;
    result.additional_count = ar_d;
    result.query_type       = type_d;
    result.query_class      = class_d;
    result.name_length      = count_d;
    result.final_result     = (emit_kind != dqqp_pkg::KIND_CHAR);
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dqqp_pkg::PH_HEADER;
      bpos_q  <= 4'd0;
      id_q    <= 16'd0;
      flags_q <= 16'd0;
      qd_q    <= 16'd0;
      an_q    <= 16'd0;
      ns_q    <= 16'd0;
      ar_q    <= 16'd0;
      type_q  <= 16'd0;
      class_q <= 16'd0;
      left_q  <= 8'd0;
      count_q <= 8'd0;
      first_q <= 1'b1;
    end else if (accept) begin
      if (restart) begin
        phase_q <= dqqp_pkg::PH_HEADER;
        bpos_q  <= 4'd0;
        id_q    <= 16'd0;
        flags_q <= 16'd0;
        qd_q    <= 16'd0;
        an_q    <= 16'd0;
        ns_q    <= 16'd0;
        ar_q    <= 16'd0;
        type_q  <= 16'd0;
        class_q <= 16'd0;
        left_q  <= 8'd0;
        count_q <= 8'd0;
        first_q <= 1'b1;
      end else begin
        phase_q <= phase_d;
        bpos_q  <= bpos_d;
        id_q    <= id_d;
        flags_q <= flags_d;
        qd_q    <= qd_d;
        an_q    <= an_d;
        ns_q    <= ns_d;
        ar_q    <= ar_d;
        type_q  <= type_d;
        class_q <= class_d;
        left_q  <= left_d;
        count_q <= count_d;
        first_q <= first_d;
      end
    end
  end

  // Output register with skid entry
  assign in_ready_o = !skid_valid_q;
  assign pop        = out_valid_q && out_ready_i;
  assign push       = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) out_valid_q  <= 1'b1;
      else                     skid_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (!out_valid_q || pop) out_q  <= result;
      else                     skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- src/dqqp_checker.sv -----
// Port-level checker for the DNS query question parser, with its bind.
// Depends on dqqp_pkg and dns_query_question_parser_core.
`default_nettype none

module dqqp_checker #(
  parameter int unsigned MAX_NAME_LEN = 255
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire dqqp_pkg::out_t out_data_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Final flag matches the kind
  a_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.kind == dqqp_pkg::KIND_CHAR) == !out_data_o.final_result))
    else $error("final flag disagrees with kind");

  // Non-character results carry no character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != dqqp_pkg::KIND_CHAR) |->
      (out_data_o.name_char == 8'd0))
    else $error("final result carries a character");

  // A name character is counted and within the limit
  a_char_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == dqqp_pkg::KIND_CHAR) |->
      (out_data_o.name_length != 8'd0) &&
      (out_data_o.name_length <= 8'(MAX_NAME_LEN)))
    else $error("name length out of range on a character");

endmodule

bind dns_query_question_parser_core dqqp_checker #(
  .MAX_NAME_LEN(MAX_NAME_LEN)
) u_dqqp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ----- bench/dns_query_question_parser_core_test.sv -----
`timescale 1ns / 1ps
// Testbench for dns_query_question_parser_core. It sends DNS messages byte by byte,
// predicts every result with a local parser model and checks the output stream.
// Depends on dqqp_pkg and the core RTL.
module dns_query_question_parser_core_test;

  localparam int          ClkPeriod = 8;
  localparam int unsigned NameLimit = 255;

  // DUT signals
  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  dqqp_pkg::in_t  in_data_i   = '0;
  logic           out_ready_i = 1'b0;
  logic           in_ready_o;
  logic           out_valid_o;
  dqqp_pkg::out_t out_data_o;

  // Traffic shaping
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int bytes_sent    = 0;
  int err_count     = 0;

  // Parser model state
  dqqp_pkg::phase_e prs_phase;
  logic [3:0]       prs_pos;
  logic [15:0]      hdr_word [6];  // id, flags, qd, an, ns, ar
  logic [7:0]       label_left;
  logic [7:0]       name_count;
  logic             first_label;
  logic [15:0]      qtype_word;
  logic [15:0]      qclass_word;

  dqqp_pkg::out_t parsed_q [$];   // results still owed by the parser
  logic [7:0]     msg_bytes [$];  // message under construction
  dqqp_pkg::out_t want_r;

  dns_query_question_parser_core #(
    .MAX_NAME_LEN(NameLimit)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  task automatic reset_parser();
    prs_phase   = dqqp_pkg::PH_HEADER;
    prs_pos     = '0;
    foreach (hdr_word[i]) hdr_word[i] = '0;
    label_left  = '0;
    name_count  = '0;
    first_label = 1'b1;
    qtype_word  = '0;
    qclass_word = '0;
  endtask

  function automatic dqqp_pkg::out_t snapshot(dqqp_pkg::kind_e k, logic [7:0] ch);
    dqqp_pkg::out_t r;
    r.kind             = k;
    r.name_char        = ch;
    r.query_id         = hdr_word[0];
    r.flag_bits        = hdr_word[1];
    r.question_count   = hdr_word[2];
    r.answer_count     = hdr_word[3];
    r.authority_count  = hdr_word[4];
    r.additional_count = hdr_word[5];
    r.query_type       = qtype_word;
    r.query_class      = qclass_word;
    r.name_length      = name_count;
    r.final_result     = (k != dqqp_pkg::KIND_CHAR);
    return r;
  endfunction

  // Final result: restart on the last byte, else skip to the end of message
  task automatic end_message(dqqp_pkg::kind_e k, logic last);
    parsed_q.push_back(snapshot(k, 8'h00));
    if (last) reset_parser();
    else prs_phase = dqqp_pkg::PH_SKIP;
  endtask

  task automatic parse_byte(logic [7:0] b, logic last);
    int idx;
    case (prs_phase)
      dqqp_pkg::PH_HEADER: begin
        idx = int'(prs_pos >> 1);
        hdr_word[idx] = {hdr_word[idx][7:0], b};
        prs_pos = prs_pos + 4'd1;
        if (prs_pos < dqqp_pkg::HeaderBytes) begin
          if (last) end_message(dqqp_pkg::KIND_SHORT_HDR, 1'b1);
        end else if (hdr_word[1][15]) begin
          end_message(dqqp_pkg::KIND_RESPONSE, last);
        end else if (last) begin
          end_message(dqqp_pkg::KIND_TRUNCATED, 1'b1);
        end else begin
          prs_phase = dqqp_pkg::PH_LENGTH;
          prs_pos   = '0;
        end
      end
      dqqp_pkg::PH_LENGTH: begin
        if (b == 8'd0) begin
          if (last) end_message(dqqp_pkg::KIND_TRUNCATED, 1'b1);
          else begin
            prs_phase = dqqp_pkg::PH_TAIL;
            prs_pos   = '0;
          end
        end else if (!first_label) begin
          if (name_count >= NameLimit) end_message(dqqp_pkg::KIND_NAME_LONG, last);
          else if (last) end_message(dqqp_pkg::KIND_TRUNCATED, 1'b1);
          else begin
            name_count = name_count + 8'd1;
            label_left = b;
            prs_phase  = dqqp_pkg::PH_CHARS;
            parsed_q.push_back(snapshot(dqqp_pkg::KIND_CHAR, dqqp_pkg::DotChar));
          end
        end else if (last) begin
          end_message(dqqp_pkg::KIND_TRUNCATED, 1'b1);
        end else begin
          first_label = 1'b0;
          label_left  = b;
          prs_phase   = dqqp_pkg::PH_CHARS;
        end
      end
      dqqp_pkg::PH_CHARS: begin
        if (name_count >= NameLimit) end_message(dqqp_pkg::KIND_NAME_LONG, last);
        else if (last) end_message(dqqp_pkg::KIND_TRUNCATED, 1'b1);
        else begin
          name_count = name_count + 8'd1;
          label_left = label_left - 8'd1;
          if (label_left == 8'd0) prs_phase = dqqp_pkg::PH_LENGTH;
          parsed_q.push_back(snapshot(dqqp_pkg::KIND_CHAR, b));
        end
      end
      dqqp_pkg::PH_TAIL: begin
        if (prs_pos < 4'd2) qtype_word = {qtype_word[7:0], b};
        else qclass_word = {qclass_word[7:0], b};
        prs_pos = prs_pos + 4'd1;
        if (prs_pos >= 4'd4) end_message(dqqp_pkg::KIND_QUERY_OK, last);
        else if (last) end_message(dqqp_pkg::KIND_TRUNCATED, 1'b1);
      end
      default: begin
        if (last) reset_parser();
      end
    endcase
  endtask

  // ---------------------------------------------------------------- driving

  // One request on the input channel; prediction happens on acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= dqqp_pkg::in_t'({b, last});
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_msg();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  task automatic put_word(logic [15:0] w);
    msg_bytes.push_back(w[15:8]);
    msg_bytes.push_back(w[7:0]);
  endtask

  task automatic put_header(logic [15:0] id, logic [15:0] flags, logic [15:0] qd,
                            logic [15:0] an, logic [15:0] ns, logic [15:0] ar);
    put_word(id);
    put_word(flags);
    put_word(qd);
    put_word(an);
    put_word(ns);
    put_word(ar);
  endtask

  task automatic put_query_header();
    put_header(16'($urandom), 16'($urandom) & 16'h7FFF, 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic put_label(int len);
    msg_bytes.push_back(8'(len));
    repeat (len) msg_bytes.push_back(8'($urandom));
  endtask

  // Labels then the terminating zero length
  task automatic put_name(int labels, int max_len);
    repeat (labels) put_label($urandom_range(1, max_len));
    msg_bytes.push_back(8'h00);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // ---------------------------------------------------------------- receiving

  // Hold-off counter for the long receiver stall
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_left != 0) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic string describe(dqqp_pkg::out_t r);
    return $sformatf({"kind=%0d char=%h id=%h flags=%h qd=%h an=%h ns=%h ar=%h ",
                      "type=%h class=%h len=%0d final=%b"},
                     r.kind, r.name_char, r.query_id, r.flag_bits, r.question_count,
                     r.answer_count, r.authority_count, r.additional_count,
                     r.query_type, r.query_class, r.name_length, r.final_result);
  endfunction

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parsed_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result: %s", describe(out_data_o));
      end else begin
        want_r = parsed_q.pop_front();
        if (out_data_o.kind !== want_r.kind ||
            out_data_o.name_char !== want_r.name_char ||
            out_data_o.query_id !== want_r.query_id ||
            out_data_o.flag_bits !== want_r.flag_bits ||
            out_data_o.question_count !== want_r.question_count ||
            out_data_o.answer_count !== want_r.answer_count ||
            out_data_o.authority_count !== want_r.authority_count ||
            out_data_o.additional_count !== want_r.additional_count ||
            out_data_o.query_type !== want_r.query_type ||
            out_data_o.query_class !== want_r.query_class ||
            out_data_o.name_length !== want_r.name_length ||
            out_data_o.final_result !== want_r.final_result) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected: %s", describe(want_r));
            $display("  actual:   %s", describe(out_data_o));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_short_header();
    msg_bytes.push_back(8'hFF);
    send_msg();
    repeat (11) msg_bytes.push_back(8'($urandom));
    send_msg();
  endtask

  task automatic test_response_bit();
    // response bit on a twelfth byte that also ends the message
    put_header(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_msg();
    // response followed by bytes that must be skipped
    put_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_label(2);
    send_msg();
  endtask

  task automatic test_root_name();
    put_header(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    msg_bytes.push_back(8'h00);
    put_word(16'hFFFF);
    put_word(16'h0000);
    send_msg();
  endtask

  task automatic test_early_end();
    // end on the twelfth byte
    put_header(16'h1234, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_msg();
    // end on the first length byte
    put_query_header();
    msg_bytes.push_back(8'h03);
    send_msg();
    // end inside a label
    put_query_header();
    msg_bytes.push_back(8'h03);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    send_msg();
    // end inside qtype/qclass
    put_query_header();
    put_name(2, 3);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h01);
    send_msg();
  endtask

  task automatic test_trailing_bytes();
    put_query_header();
    put_name(2, 4);
    put_word(16'h0001);
    put_word(16'h0001);
    repeat (3) msg_bytes.push_back(8'($urandom));
    send_msg();
    put_query_header();
    put_name(1, 5);
    put_word(16'($urandom));
    put_word(16'($urandom));
    send_msg();
  endtask

  task automatic test_long_name();
    // exactly at the limit: summary with full name length
    put_query_header();
    put_name(4, 63);
    msg_bytes.delete();
    put_query_header();
    repeat (4) put_label(63);
    msg_bytes.push_back(8'h00);
    put_word(16'($urandom));
    put_word(16'($urandom));
    send_msg();
    // at the limit, next label starts on the last byte: long name wins
    put_query_header();
    repeat (4) put_label(63);
    msg_bytes.push_back(8'h05);
    send_msg();
    // one 255-byte label, then another label: overflow with skip
    put_query_header();
    put_label(255);
    put_label(2);
    msg_bytes.push_back(8'h00);
    put_word(16'($urandom));
    put_word(16'($urandom));
    send_msg();
    // five random labels of up to 60 bytes: overflows only when the name runs past the limit
    put_query_header();
    put_name(5, 60);
    put_word(16'($urandom));
    put_word(16'($urandom));
    send_msg();
  endtask

  // Receiver holds off while a long name streams in and fills the block
  task automatic test_backpressure();
    set_idling(0, 0);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_left <= 300;
    put_query_header();
    repeat (4) put_label(40);
    msg_bytes.push_back(8'h00);
    put_word(16'($urandom));
    put_word(16'($urandom));
    send_msg();
  endtask

  task automatic test_random_traffic(int count);
    int target;
    int pick;
    int cut;
    int n;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        // well-formed query, sometimes root name or trailing bytes
        put_query_header();
        put_name($urandom_range(0, 4), ($urandom_range(0, 9) == 0) ? 63 : 12);
        put_word(16'($urandom));
        put_word(16'($urandom));
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3))
          msg_bytes.push_back(8'($urandom));
      end else if (pick < 66) begin
        put_header(16'($urandom), 16'($urandom) | 16'h8000, 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
      end else if (pick < 80) begin
        // well-formed query cut short anywhere
        put_query_header();
        put_name($urandom_range(0, 3), 10);
        put_word(16'($urandom));
        put_word(16'($urandom));
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 11)) msg_bytes.push_back(8'($urandom));
      end else if (pick < 89) begin
        put_query_header();
        put_name(5, 63);
        put_word(16'($urandom));
        put_word(16'($urandom));
      end else begin
        // noise with stray end marks, closed by a final byte
        n = $urandom_range(1, 24);
        repeat (n) send_byte(8'($urandom), ($urandom_range(0, 9) == 0));
        msg_bytes.push_back(8'($urandom));
      end
      send_msg();
    end
  endtask

  task automatic drain();
    for (int i = 0; i < 20000 && parsed_q.size() != 0; i++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    err_count += parsed_q.size();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_parser();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_header();
    test_response_bit();
    test_root_name();
    test_early_end();
    test_trailing_bytes();
    test_long_name();
    test_backpressure();

    set_idling(0, 0);
    test_random_traffic(190);
    set_idling(77, 0);
    test_random_traffic(190);
    set_idling(0, 77);
    test_random_traffic(190);
    set_idling(8, 8);
    test_random_traffic(190);

    in_valid_i <= 1'b0;
    drain();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
